// ===== hdl/cmdabbr_pkg.sv =====
// Shared types and constants of the command abbreviation matcher.
`default_nettype none

package cmdabbr_pkg;

    // Item kinds carried by the command field.
    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_LINE = 1'b1
    } cmd_t;

    // Configuration register indexes.
    typedef enum logic {
        REG_MIN_MATCH      = 1'b0,
        REG_ENTRIES_IN_USE = 1'b1
    } reg_index_t;

    localparam int unsigned CFG_DATA_W = 5;

    localparam logic [7:0] CHAR_NUL    = 8'h00;
    localparam logic [7:0] CHAR_BLANK  = 8'h20;
    localparam logic [7:0] CHAR_EQUALS = 8'h3D;
    localparam logic [7:0] CHAR_LOW_A  = 8'h61;
    localparam logic [7:0] CHAR_LOW_Z  = 8'h7A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;
    localparam logic [7:0] RUN_MAX     = 8'hFF;

    typedef struct packed {
        logic [4:0] min_match;
        logic [4:0] entries_in_use;
    } cfg_t;

    typedef struct packed {
        logic [4:0] command_number;
        logic [4:0] match_length;
        logic [7:0] consumed;
    } result_t;

endpackage

`default_nettype wire

// ===== hdl/cmdabbr_if.sv =====
// Valid/ready channel interfaces for line items and match results.
`default_nettype none

interface cmdabbr_item_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [3:0] entry;
    logic [3:0] position;
    logic [7:0] char_code;

    modport source (output valid, command, entry, position, char_code, input ready);
    modport sink   (input valid, command, entry, position, char_code, output ready);
endinterface

interface cmdabbr_result_if;
    logic       valid;
    logic       ready;
    logic [4:0] command_number;
    logic [4:0] match_length;
    logic [7:0] consumed;

    modport source (output valid, command_number, match_length, consumed, input ready);
    modport sink   (input valid, command_number, match_length, consumed, output ready);
endinterface

`default_nettype wire

// ===== hdl/cmdabbr_ram.sv =====
// Generic single-port-write, registered-read RAM with a bit write mask.
`default_nettype none

module cmdabbr_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                             clk,
    input  wire logic                             we,
    input  wire logic [$clog2(DEPTH)-1:0]         waddr,
    input  wire logic [WIDTH-1:0]                 wmask,
    input  wire logic [WIDTH-1:0]                 wdata,
    input  wire logic                             re,
    input  wire logic [$clog2(DEPTH)-1:0]         raddr,
    output logic      [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= (mem[waddr] & ~wmask) | (wdata & wmask);
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/cmdabbr_match.sv =====
// Compare stage: per-entry character compare and the line match state.
`default_nettype none

module cmdabbr_match #(
    parameter int unsigned NUM_ENTRIES = 16,
    parameter int unsigned ENTRY_LEN   = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  step,
    input  wire logic [7:0]                            char_code,
    input  wire logic [$clog2(ENTRY_LEN+1)-1:0]        pos,
    input  wire logic [NUM_ENTRIES*8-1:0]              row,
    input  wire cmdabbr_pkg::cfg_t                     cfg,
    output cmdabbr_pkg::result_t                       res
);
    import cmdabbr_pkg::*;

    localparam int unsigned PW = $clog2(ENTRY_LEN + 1);
    localparam int unsigned EW = $clog2(NUM_ENTRIES + 1);

    logic [NUM_ENTRIES-1:0] active_reg, active_next;
    logic [PW-1:0]          best_len_reg, best_len_next;
    logic [EW-1:0]          best_entry_reg, best_entry_next;
    logic [7:0]             run_reg, run_next;
    logic                   counting_reg, counting_next;

    logic [NUM_ENTRIES-1:0] fin;
    logic [EW-1:0]          first_idx;
    logic [7:0]             c_up;
    logic                   stop_ok;
    logic                   pos_in;
    logic                   qual;
    logic                   hit;
    logic [8:0]             total;

    always_comb
    begin
        c_up    = (char_code >= CHAR_LOW_A && char_code <= CHAR_LOW_Z)
                  ? char_code - CASE_OFFSET : char_code;
        stop_ok = (char_code == CHAR_NUL) || (char_code == CHAR_BLANK)
                  || (char_code == CHAR_EQUALS);
        pos_in  = pos < PW'(ENTRY_LEN);
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            logic [7:0] t;
            t = pos_in ? row[i*8 +: 8] : CHAR_NUL;
            fin[i] = (7'(i) < {2'b00, cfg.entries_in_use}) && active_reg[i]
                     && ((t == CHAR_NUL) || (c_up != t));
        end
        // Lowest finishing entry wins a tie.
        first_idx = '0;
        for (int i = NUM_ENTRIES - 1; i >= 0; i--)
        begin
            if (fin[i])
            begin
                first_idx = EW'(i);
            end
        end
        qual = stop_ok && (8'(pos) >= 8'(cfg.min_match)) && (pos > best_len_reg);
        hit  = qual && (|fin);

        active_next     = active_reg & ~fin;
        best_len_next   = hit ? pos : best_len_reg;
        best_entry_next = hit ? first_idx + EW'(1) : best_entry_reg;

        if (hit || pos == '0)
        begin
            counting_next = (char_code == CHAR_BLANK);
            run_next      = counting_next ? 8'd1 : 8'd0;
        end
        else if (counting_reg && char_code == CHAR_BLANK)
        begin
            counting_next = 1'b1;
            run_next      = (run_reg == RUN_MAX) ? run_reg : run_reg + 8'd1;
        end
        else
        begin
            counting_next = 1'b0;
            run_next      = run_reg;
        end

        total = 9'(best_len_next) + {1'b0, run_next};
        res.command_number = 5'(best_entry_next);
        res.match_length   = 5'(best_len_next);
        res.consumed       = total[8] ? RUN_MAX : total[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= '1;
            best_len_reg   <= '0;
            best_entry_reg <= '0;
            run_reg        <= '0;
            counting_reg   <= 1'b0;
        end
        else if (step)
        begin
            if (char_code == CHAR_NUL)
            begin
                active_reg     <= '1;
                best_len_reg   <= '0;
                best_entry_reg <= '0;
                run_reg        <= '0;
                counting_reg   <= 1'b0;
            end
            else
            begin
                active_reg     <= active_next;
                best_len_reg   <= best_len_next;
                best_entry_reg <= best_entry_next;
                run_reg        <= run_next;
                counting_reg   <= counting_next;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/command_abbreviation_matcher.sv =====
// Top level of the command abbreviation matcher.
//
//   Channel   Dir  Payload                                        Transfer rule
//   item      in   command, entry, position, char_code            valid & ready
//   result    out  command_number, match_length, consumed         valid & ready
//   cfg       in   cfg_index, cfg_data                            cfg_we
//
// One item is taken per cycle while the input is not stalled. A result enters the
// output register when the zero character that ends the line retires from the
// compare stage; the row of the table memory is read while that character is held there.
// The table is kept as one memory row per character position, holding that
// character of every entry, so one read feeds all entry compares at once.
// Reset clears the line state and the registers; the table contents stay
// undefined until written, and there is no clearing pass.
// The input stalls only while a line end sits in the compare stage and the
// previous result has not yet been taken from the output register.
`default_nettype none

module command_abbreviation_matcher #(
    parameter int unsigned NUM_ENTRIES = 16,
    parameter int unsigned ENTRY_LEN   = 16
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    cmdabbr_item_if.sink                                item,
    cmdabbr_result_if.source                            result,
    input  wire logic                                   cfg_we,
    input  wire logic                                   cfg_index,
    input  wire logic [cmdabbr_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import cmdabbr_pkg::*;

    localparam int unsigned RW = NUM_ENTRIES * 8;
    localparam int unsigned AW = $clog2(ENTRY_LEN);
    localparam int unsigned PW = $clog2(ENTRY_LEN + 1);

    // Configuration registers.
    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_MIN_MATCH:      cfg_reg.min_match      <= cfg_data;
                REG_ENTRIES_IN_USE: cfg_reg.entries_in_use <= cfg_data;
                default:            cfg_reg                <= cfg_reg;
            endcase
        end
    end

    // Issue stage: table writes go straight to memory; a line character
    // launches the read of its row. The position is tracked here so that the
    // next character can issue without waiting for the compare stage.
    logic          item_fire;
    logic          line_fire;
    logic          load_fire;
    logic [PW-1:0] pos_issue_reg;
    logic [RW-1:0] wmask;
    logic [RW-1:0] row;

    assign item_fire = item.valid && item.ready;
    assign line_fire = item_fire && (cmd_t'(item.command) == CMD_LINE);
    assign load_fire = item_fire && (cmd_t'(item.command) == CMD_LOAD)
                       && (7'(item.entry) < 7'(NUM_ENTRIES))
                       && (7'(item.position) < 7'(ENTRY_LEN));

    always_comb
    begin
        for (int l = 0; l < NUM_ENTRIES; l++)
        begin
            wmask[l*8 +: 8] = (7'(item.entry) == 7'(l)) ? 8'hFF : 8'h00;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_issue_reg <= '0;
        end
        else if (line_fire)
        begin
            if (item.char_code == CHAR_NUL)
            begin
                pos_issue_reg <= '0;
            end
            else if (pos_issue_reg < PW'(ENTRY_LEN))
            begin
                pos_issue_reg <= pos_issue_reg + PW'(1);
            end
        end
    end

    cmdabbr_ram #(
        .WIDTH (RW),
        .DEPTH (ENTRY_LEN)
    ) u_table (
        .clk   (clk),
        .we    (load_fire),
        .waddr (AW'(item.position)),
        .wmask (wmask),
        .wdata ({NUM_ENTRIES{item.char_code}}),
        .re    (line_fire),
        .raddr (AW'(pos_issue_reg)),
        .rdata (row)
    );

    // Compare stage. It holds one line character while its row is read; it
    // retires unless it ends the line and the output register holds a result that is not being taken.
    logic          s1_valid_reg;
    logic [7:0]    s1_char_reg;
    logic [PW-1:0] s1_pos_reg;
    logic          s1_term;
    logic          s1_done;
    logic          res_valid_reg;
    result_t       res_reg;
    result_t       res_now;

    assign s1_term    = (s1_char_reg == CHAR_NUL);
    assign s1_done    = s1_valid_reg && (!s1_term || !res_valid_reg || result.ready);
    assign item.ready = !s1_valid_reg || s1_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            s1_valid_reg <= line_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (line_fire)
        begin
            s1_char_reg <= item.char_code;
            s1_pos_reg  <= pos_issue_reg;
        end
    end

    cmdabbr_match #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .ENTRY_LEN   (ENTRY_LEN)
    ) u_match (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (s1_done),
        .char_code (s1_char_reg),
        .pos       (s1_pos_reg),
        .row       (row),
        .cfg       (cfg_reg),
        .res       (res_now)
    );

    // Output register: the finished result waits here for its transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (s1_done && s1_term)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_done && s1_term)
        begin
            res_reg <= res_now;
        end
    end

    assign result.valid          = res_valid_reg;
    assign result.command_number = res_reg.command_number;
    assign result.match_length   = res_reg.match_length;
    assign result.consumed       = res_reg.consumed;

endmodule

`default_nettype wire

// ===== hdl/cmdabbr_checker.sv =====
// Port-level checks of the command abbreviation matcher and their binding.
`default_nettype none

module cmdabbr_checker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       res_valid,
    input  wire logic       res_ready,
    input  wire logic [4:0] res_number,
    input  wire logic [4:0] res_length,
    input  wire logic [7:0] res_consumed
);

    // A stalled result stays offered.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its payload.
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_number) && $stable(res_length)
            && $stable(res_consumed))
        else $error("result payload changed while stalled");

    // No command matched exactly when no characters were matched.
    a_none_means_empty: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ((res_number == 5'd0) == (res_length == 5'd0)))
        else $error("command number and match length disagree");

    // The consumed count never falls short of the match itself.
    a_consumed_covers: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> ({3'b000, res_length} <= res_consumed))
        else $error("consumed count below match length");

endmodule

bind command_abbreviation_matcher cmdabbr_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (result.valid),
    .res_ready    (result.ready),
    .res_number   (result.command_number),
    .res_length   (result.match_length),
    .res_consumed (result.consumed)
);

`default_nettype wire
